// File: sv/erc_pkg.sv
// Shared types and constants of the expert range coalescer.
package erc_pkg;

    localparam int DEF_NUM_EXPERTS = 64;
    localparam int MAX_RANGES      = 32;
    localparam int NFOUND_W        = $clog2(MAX_RANGES);

    localparam int COUNT_W   = 7;
    localparam int STRIDE_W  = 40;
    localparam int BYTES_W   = 48;
    localparam int ID_W      = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(64);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_EXPERT_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPERT_STRIDE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_BYTES  = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WHOLE,
        ST_FINAL
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic mark;        // index request accepted
        logic start;       // reset the bitmap walk
        logic step;        // advance the walk by one expert
        logic emit_whole;  // load the whole-weight range, clear bitmap
        logic emit_final;  // load the closing range or the empty marker, clear bitmap
    } t_ctrl_cmd;

    // datapath -> controller
    typedef struct packed {
        logic whole;       // count <= 1 or stride == 0
        logic step_ok;     // the walk may advance this cycle
        logic scan_done;   // this step is the last one of the walk
        logic out_free;    // output register can take a request
    } t_dp_status;

endpackage

// File: sv/erc_ctrl.sv
// Controller state machine of the expert range coalescer.
module erc_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_last_id,
    output logic                  o_in_ready,
    input  erc_pkg::t_dp_status   i_status,
    output erc_pkg::t_ctrl_cmd    o_cmd
);
    import erc_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid && i_last_id) begin
                    n_state = i_status.whole ? ST_WHOLE : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (i_status.step_ok && i_status.scan_done) begin
                    n_state = ST_FINAL;
                end
            end
            ST_WHOLE: begin
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_FINAL: begin
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.mark = i_in_valid;
                o_cmd.start = i_in_valid && i_last_id && !i_status.whole;
            end
            ST_SCAN: begin
                o_cmd.step = i_status.step_ok;
            end
            ST_WHOLE: begin
                o_cmd.emit_whole = i_status.out_free;
            end
            ST_FINAL: begin
                o_cmd.emit_final = i_status.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

// File: sv/erc_datapath.sv
// Datapath of the expert range coalescer: config, bitmap, walk and output register.
module erc_datapath #(
    parameter int NUM_EXPERTS = erc_pkg::DEF_NUM_EXPERTS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  erc_pkg::t_ctrl_cmd                i_cmd,
    output erc_pkg::t_dp_status               o_status,
    input  logic                              i_cfg_valid,
    input  logic [erc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [erc_pkg::BYTES_W-1:0]       i_cfg_data,
    input  logic signed [erc_pkg::ID_W-1:0]   i_expert_id,
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output logic [erc_pkg::BYTES_W-1:0]       o_range_offset,
    output logic [erc_pkg::BYTES_W-1:0]       o_range_length,
    output logic                              o_last_range,
    output logic                              o_no_range
);
    import erc_pkg::*;

    localparam int IW = $clog2(NUM_EXPERTS + 1);
    localparam int AW = $clog2(NUM_EXPERTS);

    logic [COUNT_W-1:0]     r_count;
    logic [STRIDE_W-1:0]    r_stride;
    logic [BYTES_W-1:0]     r_weight;
    logic [NUM_EXPERTS-1:0] r_map;

    logic [IW-1:0]          r_idx;
    logic [BYTES_W-1:0]     r_pos;
    logic [BYTES_W-1:0]     r_first;
    logic                   r_in_run;
    logic                   r_pend_valid;
    logic [BYTES_W-1:0]     r_pend_off;
    logic [BYTES_W-1:0]     r_pend_end;
    logic [NFOUND_W-1:0]    r_nfound;

    logic                   r_out_valid;
    logic [BYTES_W-1:0]     r_out_off;
    logic [BYTES_W-1:0]     r_out_len;
    logic                   r_out_last;
    logic                   r_out_empty;

    logic [IW-1:0]          eff_cnt;
    logic                   mark_hit;
    logic                   at_end;
    logic                   bit_now;
    logic                   close_run;
    logic                   new_range;
    logic                   push;
    logic                   out_free;
    logic [BYTES_W-1:0]     end_clamped;
    logic [BYTES_W-1:0]     pend_len;

    always_comb begin
        if (int'(r_count) < NUM_EXPERTS) begin
            eff_cnt = IW'(r_count);
        end else begin
            eff_cnt = IW'(NUM_EXPERTS);
        end
    end

    assign mark_hit    = !i_expert_id[ID_W-1] && ($unsigned(i_expert_id) < ID_W'(eff_cnt));
    assign at_end      = (r_idx >= eff_cnt);
    assign bit_now     = !at_end && r_map[r_idx[AW-1:0]];
    assign close_run   = r_in_run && !bit_now;
    assign new_range   = close_run && (r_first < r_weight);
    assign push        = new_range && r_pend_valid;
    assign out_free    = !r_out_valid || i_out_ready;
    assign end_clamped = (r_pos < r_weight) ? r_pos : r_weight;
    assign pend_len    = r_pend_end - r_pend_off;

    assign o_status.whole     = (r_count <= COUNT_W'(1)) || (r_stride == '0);
    assign o_status.step_ok   = !push || out_free;
    assign o_status.scan_done = at_end || (new_range && (r_nfound == NFOUND_W'(MAX_RANGES - 1)));
    assign o_status.out_free  = out_free;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= COUNT_RESET;
            r_stride <= '0;
            r_weight <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_EXPERT_COUNT:  r_count  <= i_cfg_data[COUNT_W-1:0];
                CFG_EXPERT_STRIDE: r_stride <= i_cfg_data[STRIDE_W-1:0];
                CFG_WEIGHT_BYTES:  r_weight <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // selection bitmap
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map <= '0;
        end else if (i_cmd.emit_whole || i_cmd.emit_final) begin
            r_map <= '0;
        end else if (i_cmd.mark && mark_hit) begin
            r_map[i_expert_id[AW-1:0]] <= 1'b1;
        end
    end

    // walk control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx        <= '0;
            r_in_run     <= 1'b0;
            r_pend_valid <= 1'b0;
            r_nfound     <= '0;
        end else if (i_cmd.start) begin
            r_idx        <= '0;
            r_in_run     <= 1'b0;
            r_pend_valid <= 1'b0;
            r_nfound     <= '0;
        end else if (i_cmd.step) begin
            r_idx    <= r_idx + IW'(1);
            r_in_run <= bit_now;
            if (new_range) begin
                r_pend_valid <= 1'b1;
                r_nfound     <= r_nfound + NFOUND_W'(1);
            end
        end
    end

    // walk payload: running byte position, run start, held range
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_pos <= '0;
        end else if (i_cmd.step) begin
            r_pos <= r_pos + BYTES_W'(r_stride);
            if (bit_now && !r_in_run) begin
                r_first <= r_pos;
            end
            if (new_range) begin
                r_pend_off <= r_first;
                r_pend_end <= end_clamped;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_whole || i_cmd.emit_final || (i_cmd.step && push)) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_whole) begin
            r_out_off   <= '0;
            r_out_len   <= r_weight;
            r_out_last  <= 1'b1;
            r_out_empty <= 1'b0;
        end else if (i_cmd.emit_final) begin
            r_out_last <= 1'b1;
            if (r_pend_valid) begin
                r_out_off   <= r_pend_off;
                r_out_len   <= pend_len;
                r_out_empty <= 1'b0;
            end else begin
                r_out_off   <= '0;
                r_out_len   <= '0;
                r_out_empty <= 1'b1;
            end
        end else if (i_cmd.step && push) begin
            r_out_off   <= r_pend_off;
            r_out_len   <= pend_len;
            r_out_last  <= 1'b0;
            r_out_empty <= 1'b0;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_range_offset = r_out_off;
    assign o_range_length = r_out_len;
    assign o_last_range   = r_out_last;
    assign o_no_range     = r_out_empty;

    // a range pushed out of the hold slot never overwrites an untaken request
    a_push_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.step && push) |-> out_free)
        else $error("range pushed into a busy output register");

    // bitmap is empty after every closing emission
    a_map_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit_whole || i_cmd.emit_final) |=> (r_map == '0))
        else $error("bitmap not cleared after emission");

    // the empty marker closes its set and carries a zero range
    a_empty_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_no_range) |->
            (o_last_range && (o_range_length == '0) && (o_range_offset == '0)))
        else $error("malformed empty-set result");

endmodule

// File: sv/expert_range_coalescer_unit.sv
// Top level of the expert range coalescer: controller plus datapath.
// Index requests: one accepted per cycle while idle; a non-last index only marks the bitmap.
// Last index: the bitmap walk visits one expert per cycle up to min(count, NUM_EXPERTS)
// (stopping early after MAX_RANGES ranges), then the closing range is loaded; whole-weight
// sets load a single range. Ranges leave through an output register; a stalled consumer stops the walk.
// Reset (synchronous, active low): count 64, stride 0, weight 0, bitmap cleared at once.
module expert_range_coalescer_unit #(
    parameter int NUM_EXPERTS = erc_pkg::DEF_NUM_EXPERTS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // index requests
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic signed [erc_pkg::ID_W-1:0]   i_expert_id,
    input  logic                              i_last_id,
    // configuration writes
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [erc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [erc_pkg::BYTES_W-1:0]       i_cfg_data,
    // range requests
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [erc_pkg::BYTES_W-1:0]       o_range_offset,
    output logic [erc_pkg::BYTES_W-1:0]       o_range_length,
    output logic                              o_last_range,
    output logic                              o_no_range
);
    import erc_pkg::*;

    t_ctrl_cmd  ctrl_cmd;
    t_dp_status dp_status;

    // Config writes land in the datapath registers directly; the user must issue them only while
    // the block is idle, which the block itself does not enforce. The port never back-pressures.
    assign o_cfg_ready = 1'b1;

    // Sequencer: idle marking, bitmap walk, closing emission.
    erc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_last_id  (i_last_id),
        .o_in_ready (o_in_ready),
        .i_status   (dp_status),
        .o_cmd      (ctrl_cmd)
    );

    // Bitmap, running byte position (stride added per expert, so no multiplier),
    // one-range hold slot that reveals which range is last, and output register.
    erc_datapath #(
        .NUM_EXPERTS (NUM_EXPERTS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (ctrl_cmd),
        .o_status       (dp_status),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_expert_id    (i_expert_id),
        .i_out_ready    (i_out_ready),
        .o_out_valid    (o_out_valid),
        .o_range_offset (o_range_offset),
        .o_range_length (o_range_length),
        .o_last_range   (o_last_range),
        .o_no_range     (o_no_range)
    );

endmodule

// File: sim/tb.sv
// Self-checking testbench of the expert range coalescer: directed table, then random sets.
`timescale 1ns / 1ps

module tb;
    import erc_pkg::*;

    localparam int N_EXPERTS   = DEF_NUM_EXPERTS;
    localparam int SETTLE      = N_EXPERTS + 8;   // full walk, closing range, margin
    localparam int HOLD_CYCLES = 400;             // long consumer stall, fills the output path
    localparam int RAND_ITEMS  = 200;
    localparam int CALM_ITEMS  = 40;              // tail of the run without idling

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;   // no register behind this index
    localparam logic [BYTES_W-1:0]   BYTES_MAX  = '1;
    localparam logic [STRIDE_W-1:0]  STRIDE_MAX = '1;

    typedef struct packed {
        logic [BYTES_W-1:0] range_off;
        logic [BYTES_W-1:0] range_len;
        logic               is_last;
        logic               is_empty;
    } t_range;

    typedef enum logic {ROW_CFG, ROW_ID} t_row_kind;

    // one line of the directed table; want is used only when typed is set
    typedef struct {
        t_row_kind            kind;
        logic [CFG_IDX_W-1:0] idx;
        logic [BYTES_W-1:0]   data;
        logic [ID_W-1:0]      id;
        logic                 last;
        logic                 typed;
        t_range               want;
    } t_row;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic [ID_W-1:0]      i_expert_id;
    logic                 i_last_id;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [BYTES_W-1:0]   i_cfg_data;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic [BYTES_W-1:0]   o_range_offset;
    logic [BYTES_W-1:0]   o_range_length;
    logic                 o_last_range;
    logic                 o_no_range;

    // predictor copy of the block's state and registers
    logic [N_EXPERTS-1:0] sel_map;
    logic [COUNT_W-1:0]   cur_count;
    logic [STRIDE_W-1:0]  cur_stride;
    logic [BYTES_W-1:0]   cur_weight;

    t_range ranges_due[$];   // expected range requests, oldest first
    t_range set_ranges[$];   // ranges produced by the set just closed
    t_row   plan[$];

    int err_cnt    = 0;
    int live_items = 0;      // items that mark a bit or close a set
    bit no_idle    = 1'b0;
    bit hold_req   = 1'b0;

    expert_range_coalescer_unit #(
        .NUM_EXPERTS(N_EXPERTS)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_expert_id   (i_expert_id),
        .i_last_id     (i_last_id),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_range_offset(o_range_offset),
        .o_range_length(o_range_length),
        .o_last_range  (o_last_range),
        .o_no_range    (o_no_range)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // watchdog: several times the slowest legal run
    initial begin
        #4_000_000;
        $display("expert_range_coalescer_unit regression: fail");
        $finish;
    end

    function automatic int eff_count();
        return (int'(cur_count) < N_EXPERTS) ? int'(cur_count) : N_EXPERTS;
    endfunction

    // Appends one range at the tail of a range list.
    function automatic void append_range(ref t_range q[$], input t_range r);
        q.insert(q.size(), r);
    endfunction

    // Marks the index; on a last index walks the bitmap and fills set_ranges.
    task automatic coalesce_item(input logic [ID_W-1:0] id, input logic last);
        int          cnt;
        int          e;
        int          first;
        logic [63:0] off;
        logic [63:0] len;
        logic [63:0] room;
        set_ranges.delete();
        cnt = eff_count();
        // sign bit set is a sentinel; indices past the count are dropped
        if (!id[ID_W-1] && id < cnt) sel_map[id] = 1'b1;
        if (!last) return;
        if (cur_count <= 1 || cur_stride == '0) begin
            // degenerate layout: the whole tensor in one range
            append_range(set_ranges, {{BYTES_W{1'b0}}, cur_weight, 1'b1, 1'b0});
        end else begin
            e = 0;
            while (e < cnt && set_ranges.size() < MAX_RANGES) begin
                while (e < cnt && !sel_map[e]) e++;
                if (e >= cnt) break;
                first = e;
                while (e < cnt && sel_map[e]) e++;
                off = 64'(first) * 64'(cur_stride);
                // runs starting at or past the end of the weight are skipped
                if (off < 64'(cur_weight)) begin
                    len  = 64'(e - first) * 64'(cur_stride);
                    room = 64'(cur_weight) - off;
                    if (len > room) len = room;
                    if (len > 0)
                        append_range(set_ranges,
                                     {off[BYTES_W-1:0], len[BYTES_W-1:0], 2'b00});
                end
            end
            if (set_ranges.size() == 0)
                append_range(set_ranges, {{BYTES_W{1'b0}}, {BYTES_W{1'b0}}, 1'b1, 1'b1});
            else
                set_ranges[set_ranges.size() - 1].is_last = 1'b1;
        end
        sel_map = '0;
    endtask

    // One index request; valid stays up after acceptance unless the next call idles.
    task automatic send_index(input logic [ID_W-1:0] id, input logic last,
                              input logic typed, input t_range want);
        int gap;
        gap = (!no_idle && $urandom_range(0, 3) == 0) ? $urandom_range(1, 11) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_expert_id <= id;
        i_last_id   <= last;
        do @(posedge i_clk); while (!o_in_ready);
        if (last || (!id[ID_W-1] && id < eff_count())) live_items++;
        coalesce_item(id, last);
        if (typed) begin
            append_range(ranges_due, want);
        end else begin
            foreach (set_ranges[k]) append_range(ranges_due, set_ranges[k]);
        end
    endtask

    // Wait until every range has come out and the walk has surely finished.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (ranges_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTES_W-1:0] data);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_EXPERT_COUNT: begin
                cur_count = data[COUNT_W-1:0];
            end
            CFG_EXPERT_STRIDE: begin
                cur_stride = data[STRIDE_W-1:0];
            end
            CFG_WEIGHT_BYTES: begin
                cur_weight = data;
            end
            default: begin
            end
        endcase
    endtask

    function automatic t_row cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                     input logic [BYTES_W-1:0] data);
        t_row r;
        r       = '{ROW_CFG, idx, data, '0, 1'b0, 1'b0, '0};
        return r;
    endfunction

    function automatic t_row id_row(input logic [ID_W-1:0] id, input logic last);
        t_row r;
        r       = '{ROW_ID, CFG_UNUSED, '0, id, last, 1'b0, '0};
        return r;
    endfunction

    function automatic t_row fixed_row(input logic [ID_W-1:0] id, input logic last,
                                       input logic [BYTES_W-1:0] off,
                                       input logic [BYTES_W-1:0] len,
                                       input logic fin, input logic empty);
        t_row r;
        r       = '{ROW_ID, CFG_UNUSED, '0, id, last, 1'b1, '0};
        r.want  = {off, len, fin, empty};
        return r;
    endfunction

    // Mostly in-range indices, with sentinels and just-too-large values mixed in.
    function automatic logic [ID_W-1:0] pick_index();
        int cnt;
        int sel;
        cnt = eff_count();
        sel = $urandom_range(0, 19);
        if (cnt > 0 && sel < 17) return ID_W'($urandom_range(0, cnt - 1));
        if (sel == 17) return {1'b1, 15'($urandom)};
        if (sel == 18) return ID_W'(cnt + $urandom_range(0, 3));
        return ID_W'($urandom);
    endfunction

    // New register settings for a random phase; extremes come up regularly.
    task automatic roll_settings();
        logic [BYTES_W-1:0]  junk;
        logic [STRIDE_W-1:0] s;
        logic [63:0]         span;
        logic [63:0]         cut;
        int                  sel;
        int                  v;
        junk = {16'($urandom), $urandom};
        sel  = $urandom_range(0, 19);
        if (sel < 10)       v = 64;
        else if (sel < 15)  v = $urandom_range(2, 63);
        else if (sel == 15) v = 0;
        else if (sel == 16) v = 1;
        else if (sel == 17) v = 127;
        else if (sel == 18) v = 65;
        else                v = $urandom_range(0, 127);
        // upper data bits beyond the register width must be dropped
        write_reg(CFG_EXPERT_COUNT, ($urandom_range(0, 3) == 0) ?
                  {junk[BYTES_W-1:COUNT_W], COUNT_W'(v)} : BYTES_W'(v));

        sel = $urandom_range(0, 19);
        if (sel < 2)       s = '0;
        else if (sel < 5)  s = STRIDE_MAX;
        else if (sel < 7)  s = STRIDE_W'(1);
        else if (sel < 15) s = STRIDE_W'($urandom_range(1, 65535));
        else               s = {8'($urandom), $urandom};
        write_reg(CFG_EXPERT_STRIDE, ($urandom_range(0, 3) == 0) ?
                  {junk[BYTES_W-1:STRIDE_W], s} : BYTES_W'(s));

        // weight near the end of the last expert so clipping shows up
        sel  = $urandom_range(0, 19);
        span = 64'(eff_count()) * 64'(cur_stride);
        cut  = 64'($urandom_range(0, 2)) * 64'(cur_stride) / 2;
        if (sel < 3)                write_reg(CFG_WEIGHT_BYTES, BYTES_MAX);
        else if (sel == 3)          write_reg(CFG_WEIGHT_BYTES, '0);
        else if (sel < 7 || span == 0)
            write_reg(CFG_WEIGHT_BYTES, {16'($urandom), $urandom});
        else if (span > cut)        write_reg(CFG_WEIGHT_BYTES, BYTES_W'(span - cut));
        else                        write_reg(CFG_WEIGHT_BYTES, BYTES_W'(span));

        if ($urandom_range(0, 9) == 0) write_reg(CFG_UNUSED, junk);
    endtask

    // Range consumer: random stall bursts, one long hold on request, none at the end.
    initial begin : range_sink
        int burst;
        i_out_ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_req) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (!no_idle && $urandom_range(0, 3) == 0) begin
                burst = $urandom_range(1, 11);
                i_out_ready <= 1'b0;
                repeat (burst) @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    function automatic void mismatch(input string what, input logic [BYTES_W-1:0] want,
                                     input logic [BYTES_W-1:0] got);
        err_cnt++;
        $display("%0t: %s mismatch: expected %h, got %h", $time, what, want, got);
    endfunction

    // Each accepted range request against the oldest expectation.
    always @(posedge i_clk) begin : range_check
        t_range got;
        t_range want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = {o_range_offset, o_range_length, o_last_range, o_no_range};
            if (ranges_due.size() == 0) begin
                err_cnt++;
                $display("%0t: unexpected range: expected none, got off %h len %h last %b empty %b",
                         $time, got.range_off, got.range_len, got.is_last, got.is_empty);
            end else begin
                want = ranges_due[0];
                ranges_due.delete(0);
                if (got.range_off !== want.range_off)
                    mismatch("range_offset", want.range_off, got.range_off);
                if (got.range_len !== want.range_len)
                    mismatch("range_length", want.range_len, got.range_len);
                if (got.is_last !== want.is_last)
                    mismatch("last_range", BYTES_W'(want.is_last), BYTES_W'(got.is_last));
                if (got.is_empty !== want.is_empty)
                    mismatch("no_range", BYTES_W'(want.is_empty), BYTES_W'(got.is_empty));
            end
        end
    end

    initial begin : stimulus
        int sel;
        int cnt;
        int n;
        int first;
        int goal;
        int phase;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_expert_id <= '0;
        i_last_id   <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_EXPERT_COUNT;
        i_cfg_data  <= '0;
        sel_map     = '0;
        cur_count   = COUNT_RESET;
        cur_stride  = '0;
        cur_weight  = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table. Reset leaves stride 0, so the first set is the whole
        // (zero-size) weight.
        plan.insert(plan.size(), fixed_row(16'd5, 1'b1, '0, '0, 1'b1, 1'b0));
        plan.insert(plan.size(), cfg_row(CFG_WEIGHT_BYTES, BYTES_MAX));
        plan.insert(plan.size(), fixed_row(16'hFFFF, 1'b1, '0, BYTES_MAX, 1'b1, 1'b0));
        plan.insert(plan.size(), cfg_row(CFG_EXPERT_STRIDE, BYTES_W'(16)));
        // most negative, most positive, first out-of-range: all ignored
        plan.insert(plan.size(), id_row(16'h8000, 1'b0));
        plan.insert(plan.size(), id_row(16'h7FFF, 1'b0));
        plan.insert(plan.size(), id_row(16'd64, 1'b0));
        plan.insert(plan.size(), id_row(16'd0, 1'b0));
        plan.insert(plan.size(), id_row(16'd1, 1'b0));
        plan.insert(plan.size(), id_row(16'd63, 1'b1));
        // only a sentinel in the set: the empty marker
        plan.insert(plan.size(), fixed_row(16'hFFFF, 1'b1, '0, '0, 1'b1, 1'b1));
        plan.insert(plan.size(), cfg_row(CFG_EXPERT_STRIDE, BYTES_W'(STRIDE_MAX)));
        plan.insert(plan.size(), id_row(16'd63, 1'b1));
        plan.insert(plan.size(), cfg_row(CFG_UNUSED, BYTES_MAX));
        plan.insert(plan.size(), cfg_row(CFG_WEIGHT_BYTES, BYTES_W'(100)));
        plan.insert(plan.size(), id_row(16'd0, 1'b0));
        plan.insert(plan.size(), id_row(16'd1, 1'b1));
        // run starts past the end of the weight: skipped, so empty
        plan.insert(plan.size(), fixed_row(16'd5, 1'b1, '0, '0, 1'b1, 1'b1));
        plan.insert(plan.size(), cfg_row(CFG_EXPERT_COUNT, BYTES_W'(0)));
        plan.insert(plan.size(), fixed_row(16'd0, 1'b1, '0, BYTES_W'(100), 1'b1, 1'b0));
        plan.insert(plan.size(), cfg_row(CFG_EXPERT_COUNT, BYTES_W'(1)));
        plan.insert(plan.size(), fixed_row(16'd0, 1'b1, '0, BYTES_W'(100), 1'b1, 1'b0));
        plan.insert(plan.size(), cfg_row(CFG_EXPERT_COUNT, BYTES_W'(127)));
        plan.insert(plan.size(), cfg_row(CFG_EXPERT_STRIDE, BYTES_W'(1)));
        plan.insert(plan.size(), cfg_row(CFG_WEIGHT_BYTES, BYTES_MAX));
        plan.insert(plan.size(), id_row(16'd40, 1'b0));
        // count shrinks mid-set: expert 40 is left out of the walk, yet cleared
        plan.insert(plan.size(), cfg_row(CFG_EXPERT_COUNT, BYTES_W'(32)));
        plan.insert(plan.size(), id_row(16'd3, 1'b1));
        plan.insert(plan.size(), cfg_row(CFG_EXPERT_COUNT, BYTES_W'(64)));
        plan.insert(plan.size(), id_row(16'd50, 1'b1));

        foreach (plan[r]) begin
            if (plan[r].kind == ROW_CFG) begin
                write_reg(plan[r].idx, plan[r].data);
            end else begin
                send_index(plan[r].id, plan[r].last, plan[r].typed, plan[r].want);
            end
        end

        // Random phases: new settings (sender paused until drained), then sets.
        live_items = 0;
        phase      = 0;
        while (live_items < RAND_ITEMS) begin
            no_idle = (live_items >= RAND_ITEMS - CALM_ITEMS);
            roll_settings();
            // one long consumer stall while requests keep coming
            if (phase == 2) hold_req = 1'b1;
            goal = live_items + 25;
            while (live_items < goal && live_items < RAND_ITEMS) begin
                sel = $urandom_range(0, 99);
                cnt = eff_count();
                if (sel < 55) begin
                    n = $urandom_range(1, 10);
                    for (int k = 0; k < n; k++) send_index(pick_index(), k == n - 1, 1'b0, '0);
                end else if (sel < 70 && cnt >= 1) begin
                    // contiguous block, may wrap around the count
                    first = $urandom_range(0, cnt - 1);
                    n     = $urandom_range(1, 8);
                    for (int k = 0; k < n; k++)
                        send_index(ID_W'((first + k) % cnt), k == n - 1, 1'b0, '0);
                end else if (sel < 73 && cnt >= 2) begin
                    // every other expert: the most runs a set can have
                    first = $urandom_range(0, 1);
                    for (int k = first; k < cnt; k += 2)
                        send_index(ID_W'(k), k + 2 >= cnt, 1'b0, '0);
                end else if (sel < 85) begin
                    n = $urandom_range(1, 6);
                    for (int k = 0; k < n; k++) send_index(ID_W'($urandom), k == n - 1, 1'b0, '0);
                end else if (sel < 92) begin
                    // set left open; may run into a register change
                    n = $urandom_range(1, 5);
                    for (int k = 0; k < n; k++) send_index(pick_index(), 1'b0, 1'b0, '0);
                end else begin
                    send_index(pick_index(), 1'b1, 1'b0, '0);
                end
            end
            phase++;
        end

        drain();
        if (err_cnt == 0 && ranges_due.size() == 0) begin
            $display("expert_range_coalescer_unit regression: pass");
        end else begin
            $display("expert_range_coalescer_unit regression: fail");
        end
        $finish;
    end

endmodule
